@@ sv/tds_pkg.sv @@
// Shared constants, types and fixed-point helpers of the tridiagonal solver.
`default_nettype none
package tds_pkg;

    // Sizing of the row stores and the fixed-point format.
    localparam int MAX_ROWS  = 32;
    localparam int FRAC_BITS = 16;
    localparam int ROW_AW    = $clog2(MAX_ROWS);
    localparam int CNT_W     = $clog2(MAX_ROWS + 1);
    // Width of a product after the fraction shift.
    localparam int PW        = 64 - FRAC_BITS;
    // Width of the scaled dividend.
    localparam int DW        = 32 + FRAC_BITS;

    // Status codes carried with each solution value.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_PIVOT = 2'd1;
    localparam logic [1:0] ST_ROWS  = 2'd2;

    // Error flag bits.
    localparam int ERR_PIVOT = 0;
    localparam int ERR_ROWS  = 1;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_MC,
        S_MD,
        S_MN,
        S_CHK,
        S_DC,
        S_DD,
        S_BRD,
        S_BX,
        S_BM,
        S_BOUT
    } t_state;

    // Request to the shared divider.
    typedef struct packed {
        logic               start;
        logic signed [31:0] num;
        logic signed [31:0] den;
    } t_div_req;

    // Answer of the shared divider.
    typedef struct packed {
        logic               done;
        logic signed [31:0] quo;
    } t_div_rsp;

    // Product divided by 2^FRAC_BITS, truncated toward zero.
    function automatic logic signed [PW-1:0] fx_scale(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p[63] ? (p + $signed((64'(1) << FRAC_BITS) - 64'(1))) : p;
        return PW'(t >>> FRAC_BITS);
    endfunction

    // Saturate a grown value to 32 signed bits.
    function automatic logic signed [31:0] fx_sat(input logic signed [PW:0] v);
        logic [PW-31:0] top;
        top = v[PW:31];
        if ((top == '0) || (top == '1)) begin
            return v[31:0];
        end
        return v[PW] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    endfunction

endpackage
`default_nettype wire

@@ sv/tds_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

@@ sv/tds_div.sv @@
// Iterative fixed-point divider, one quotient bit per cycle, saturating result.
`default_nettype none
module tds_div (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire tds_pkg::t_div_req     i_req,
    output tds_pkg::t_div_rsp          o_rsp
);
    import tds_pkg::*;

    localparam int SW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [SW-1:0] r_cnt;
    logic [DW-1:0] r_q;
    logic [31:0]   r_rem;
    logic [31:0]   r_d;
    logic          r_neg;
    logic [32:0]   trial;
    logic [32:0]   diff;
    logic [31:0]   mag_n;
    logic [31:0]   mag_d;

    assign mag_n = i_req.num[31] ? (32'd0 - i_req.num) : i_req.num;
    assign mag_d = i_req.den[31] ? (32'd0 - i_req.den) : i_req.den;
    assign trial = {r_rem, r_q[DW-1]};
    assign diff  = trial - {1'b0, r_d};

    // Control: busy flag, step counter and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= SW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - SW'(1);
                if (r_cnt == SW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Restoring division on magnitudes, one bit a cycle.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= {mag_n, {FRAC_BITS{1'b0}}};
            r_rem <= '0;
            r_d   <= mag_d;
            r_neg <= i_req.num[31] ^ i_req.den[31];
        end else if (r_busy) begin
            if (!diff[32]) begin
                r_rem <= diff[31:0];
                r_q   <= {r_q[DW-2:0], 1'b1};
            end else begin
                r_rem <= trial[31:0];
                r_q   <= {r_q[DW-2:0], 1'b0};
            end
        end
    end

    // Sign and saturation of the magnitude quotient.
    always_comb begin
        o_rsp.done = r_done;
        if (r_neg) begin
            if (r_q > DW'(33'h0_8000_0000)) begin
                o_rsp.quo = 32'sh8000_0000;
            end else begin
                o_rsp.quo = 32'd0 - r_q[31:0];
            end
        end else begin
            if (r_q > DW'(32'h7fff_ffff)) begin
                o_rsp.quo = 32'sh7fff_ffff;
            end else begin
                o_rsp.quo = r_q[31:0];
            end
        end
    end

endmodule
`default_nettype wire

@@ sv/tridiagonal_solver.sv @@
// Top level of the tridiagonal solver: row sequencer, shared multiplier, stores.
// Each row's time is set by the bit-serial divider that runs twice per row on
// Q16.16 values; a zero pivot row does not use the divider.
// After the last row, results leave one at a time, held while the output stalls.
// The block takes no row while a row or the back sweep is in progress.
// Synchronous active-low reset clears the sequencer, row count and error flags.
`default_nettype none
module tridiagonal_solver (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // tdata: sub_diag [31:0], diag [63:32], super_diag [95:64], rhs [127:96]
    input  wire logic [127:0]  s_axis_tdata,
    // tlast: last_row
    input  wire logic          s_axis_tlast,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // tdata: solution [31:0], row_index [37:32], zero fill [39:38]
    output logic [39:0]        m_axis_tdata,
    // tlast: last_value
    output logic               m_axis_tlast,
    // tuser: status [1:0]
    output logic [1:0]         m_axis_tuser
);
    import tds_pkg::*;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count;
    logic [1:0]         r_err;
    logic [ROW_AW-1:0]  r_idx;
    logic               r_first;
    logic signed [31:0] r_a, r_b, r_c, r_d;
    logic               r_last;
    logic signed [63:0] r_prod;
    logic signed [31:0] r_piv, r_num, r_cq, r_next;
    logic signed [31:0] r_sol;
    logic [1:0]         r_status;

    logic               accept;
    logic signed [31:0] mul_x, mul_y;
    logic signed [31:0] rd_c, rd_d;
    logic               ram_we;
    logic [31:0]        wr_c, wr_d;
    t_div_req           div_req;
    t_div_rsp           div_rsp;
    logic signed [31:0] back_x;

    assign accept = s_axis_tvalid && s_axis_tready;

    // Modified coefficient stores.
    tds_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_cstar (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ROW_AW'(r_count)),
        .i_wdata (wr_c),
        .i_raddr (r_idx),
        .o_rdata (rd_c)
    );

    tds_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_dstar (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ROW_AW'(r_count)),
        .i_wdata (wr_d),
        .i_raddr (r_idx),
        .o_rdata (rd_d)
    );

    // Shared divider for both quotients of a row.
    tds_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Solution of a back sweep row from the registered product.
    assign back_x = fx_sat((PW+1)'(rd_d) - (PW+1)'(fx_scale(r_prod)));

    // Operand selection of the shared multiplier.
    always_comb begin
        case (r_state)
            S_MC:    begin mul_x = r_a;  mul_y = rd_c; end
            S_MD:    begin mul_x = r_a;  mul_y = rd_d; end
            default: begin mul_x = rd_c; mul_y = r_next; end
        endcase
    end

    // Next state and handshake outputs.
    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        div_req.start = 1'b0;
        div_req.num   = r_c;
        div_req.den   = r_piv;
        ram_we        = 1'b0;
        wr_c          = '0;
        wr_d          = '0;
        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    if (r_count >= CNT_W'(MAX_ROWS)) begin
                        n_state = s_axis_tlast ? S_BRD : S_IDLE;
                    end else if (r_count == '0) begin
                        n_state = S_CHK;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD:  n_state = S_MC;
            S_MC:  n_state = S_MD;
            S_MD:  n_state = S_MN;
            S_MN:  n_state = S_CHK;
            S_CHK: begin
                if (r_piv == '0) begin
                    ram_we  = 1'b1;
                    n_state = r_last ? S_BRD : S_IDLE;
                end else begin
                    div_req.start = 1'b1;
                    n_state       = S_DC;
                end
            end
            S_DC: begin
                if (div_rsp.done) begin
                    div_req.start = 1'b1;
                    div_req.num   = r_num;
                    n_state       = S_DD;
                end
            end
            S_DD: begin
                if (div_rsp.done) begin
                    ram_we  = 1'b1;
                    wr_c    = r_cq;
                    wr_d    = div_rsp.quo;
                    n_state = r_last ? S_BRD : S_IDLE;
                end
            end
            S_BRD: n_state = S_BX;
            S_BX:  n_state = r_first ? S_BOUT : S_BM;
            S_BM:  n_state = S_BOUT;
            S_BOUT: begin
                if (m_axis_tready) begin
                    n_state = (r_idx == '0) ? S_IDLE : S_BRD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Row count, error flags and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_err         <= '0;
            m_axis_tvalid <= 1'b0;
        end else begin
            if (accept && (r_count >= CNT_W'(MAX_ROWS))) begin
                r_err[ERR_ROWS] <= 1'b1;
            end
            if ((r_state == S_CHK) && (r_piv == '0)) begin
                r_err[ERR_PIVOT] <= 1'b1;
            end
            if (ram_we) begin
                r_count <= r_count + CNT_W'(1);
            end
            if ((r_state == S_BX && r_first) || r_state == S_BM) begin
                m_axis_tvalid <= 1'b1;
            end else if (r_state == S_BOUT && m_axis_tready) begin
                m_axis_tvalid <= 1'b0;
                if (r_idx == '0) begin
                    r_count <= '0;
                    r_err   <= '0;
                end
            end
        end
    end

    // Datapath registers of the forward and back sweeps.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_x * mul_y;
        case (r_state)
            S_IDLE: begin
                r_a    <= s_axis_tdata[31:0];
                r_b    <= s_axis_tdata[63:32];
                r_c    <= s_axis_tlast ? 32'sd0 : s_axis_tdata[95:64];
                r_d    <= s_axis_tdata[127:96];
                r_last <= s_axis_tlast;
                r_piv  <= s_axis_tdata[63:32];
                r_num  <= s_axis_tdata[127:96];
                if (n_state != S_BRD) begin
                    r_idx <= ROW_AW'(r_count - CNT_W'(1));
                end
            end
            S_MD: r_piv <= fx_sat((PW+1)'(r_b) - (PW+1)'(fx_scale(r_prod)));
            S_MN: r_num <= fx_sat((PW+1)'(r_d) - (PW+1)'(fx_scale(r_prod)));
            S_DC: begin
                if (div_rsp.done) begin
                    r_cq <= div_rsp.quo;
                end
            end
            S_BX: begin
                if (r_first) begin
                    r_sol  <= rd_d;
                    r_next <= rd_d;
                end
            end
            S_BM: begin
                r_sol  <= back_x;
                r_next <= back_x;
            end
            S_BOUT: begin
                r_first <= 1'b0;
                if (m_axis_tready) begin
                    r_idx <= r_idx - ROW_AW'(1);
                end
            end
            default: ;
        endcase
        // Start of the back sweep at the top stored row.
        if (n_state == S_BRD && r_state != S_BOUT) begin
            r_idx    <= ROW_AW'((ram_we ? r_count + CNT_W'(1) : r_count) - CNT_W'(1));
            r_first  <= 1'b1;
            r_status <= (r_err[ERR_ROWS] || accept) ? ST_ROWS :
                        ((r_err[ERR_PIVOT] || (r_state == S_CHK && r_piv == '0))
                         ? ST_PIVOT : ST_OK);
        end
    end

    assign m_axis_tdata = {2'b00, 6'(r_idx), r_sol};
    assign m_axis_tlast = (r_idx == '0);
    assign m_axis_tuser = r_status;

endmodule
`default_nettype wire

@@ sv/tds_checker.sv @@
// Port-level checker of the tridiagonal solver and its bind.
`default_nettype none
module tds_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [39:0]  m_axis_tdata,
    input wire logic         m_axis_tlast,
    input wire logic [1:0]   m_axis_tuser
);

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // No row is taken while a result is pending.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready during back sweep");

    // The final result of a run is row zero, and only it.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[37:32] == 6'd0)))
        else $error("last mark does not match row zero");

    // Status never carries the unused code.
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser != 2'd3))
        else $error("invalid status code");

endmodule

bind tridiagonal_solver tds_checker u_tds_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

@@ verif/tridiagonal_solver_tb.sv @@
// Self-checking testbench for the tridiagonal solver: random systems, stalls and checks.
`default_nettype none
module tridiagonal_solver_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tds_pkg::*;

    // One matrix row as offered to the solver.
    typedef struct {
        logic signed [31:0] sub_diag;
        logic signed [31:0] diag;
        logic signed [31:0] super_diag;
        logic signed [31:0] rhs;
        logic               last_row;
    } t_row;

    // One solved unknown as expected from the solver.
    typedef struct {
        logic signed [31:0] solution;
        logic [5:0]         row_index;
        logic               last_value;
        logic [1:0]         status;
    } t_sol;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [39:0]  m_axis_tdata;
    logic         m_axis_tlast;
    logic [1:0]   m_axis_tuser;

    tridiagonal_solver u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    t_row pending_rows[$];
    t_sol expected_sols[$];

    // Predictor state: forward-sweep coefficients of the current system.
    logic signed [31:0] cstar_copy[MAX_ROWS];
    logic signed [31:0] dstar_copy[MAX_ROWS];
    int unsigned        rows_held;
    logic [1:0]         err_seen;

    int  fail_count;
    int  solutions_checked;
    int  systems_sent;
    int  pivot_systems;
    int  overflow_systems;
    bit  hold_sender;
    int  long_stall;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic signed [31:0] sat_to32(input logic signed [95:0] v);
        if (v > 96'sd2147483647) return 32'sh7fff_ffff;
        if (v < -96'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Fixed-point product, truncated toward zero.
    function automatic logic signed [95:0] mul_q(input logic signed [31:0] p,
                                                 input logic signed [31:0] q);
        logic signed [95:0] prod;
        prod = 96'(p) * 96'(q);
        return prod / (96'sd1 <<< FRAC_BITS);
    endfunction

    function automatic logic signed [31:0] div_q(input logic signed [31:0] n,
                                                 input logic signed [31:0] d);
        logic signed [95:0] scaled;
        scaled = 96'(n) <<< FRAC_BITS;
        return sat_to32(scaled / 96'(d));
    endfunction

    // Forward sweep on one accepted row; back sweep when the row is last.
    task automatic sweep_row(input t_row r);
        logic signed [31:0] sup, piv, num, x, nxt;
        logic [1:0]         st;
        t_sol               s;
        int                 n;
        sup = r.last_row ? 32'sd0 : r.super_diag;
        if (rows_held >= MAX_ROWS) begin
            err_seen[ERR_ROWS] = 1'b1;
        end else begin
            if (rows_held == 0) begin
                piv = r.diag;
                num = r.rhs;
            end else begin
                piv = sat_to32(96'(r.diag) - mul_q(r.sub_diag, cstar_copy[rows_held-1]));
                num = sat_to32(96'(r.rhs) - mul_q(r.sub_diag, dstar_copy[rows_held-1]));
            end
            if (piv == 0) begin
                cstar_copy[rows_held] = '0;
                dstar_copy[rows_held] = '0;
                err_seen[ERR_PIVOT] = 1'b1;
            end else begin
                cstar_copy[rows_held] = div_q(sup, piv);
                dstar_copy[rows_held] = div_q(num, piv);
            end
            rows_held++;
        end
        if (r.last_row) begin
            n = rows_held;
            st = err_seen[ERR_ROWS] ? ST_ROWS : (err_seen[ERR_PIVOT] ? ST_PIVOT : ST_OK);
            nxt = '0;
            for (int i = n - 1; i >= 0; i--) begin
                if (i == n - 1) x = dstar_copy[i];
                else x = sat_to32(96'(dstar_copy[i]) - mul_q(cstar_copy[i], nxt));
                nxt = x;
                s.solution = x;
                s.row_index = 6'(i);
                s.last_value = (i == 0);
                s.status = st;
                expected_sols.push_back(s);
            end
            rows_held = 0;
            err_seen = '0;
        end
    endtask

    function automatic logic signed [31:0] rand_word(input int mode);
        case (mode)
            0: return $signed($urandom());
            1: return $signed(32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000);
            default: return $signed(32'($urandom_range(32'h0001_0000, 32'h0006_0000)));
        endcase
    endfunction

    // Queue one system; well-conditioned rows unless noise is asked.
    task automatic add_system(input int nrows, input bit noisy);
        t_row r;
        for (int i = 0; i < nrows; i++) begin
            r.sub_diag = rand_word(noisy ? 0 : 1);
            r.super_diag = rand_word(noisy ? 0 : 1);
            r.diag = noisy ? rand_word($urandom_range(0, 2)) : rand_word(2) + 32'sh0005_0000;
            if ($urandom_range(0, 9) == 0) r.diag = -r.diag;
            r.rhs = rand_word($urandom_range(0, 1));
            r.last_row = (i == nrows - 1);
            pending_rows.push_back(r);
        end
    endtask

    task automatic add_row(input logic signed [31:0] a, b, c, d, input logic last);
        t_row r;
        r.sub_diag = a;
        r.diag = b;
        r.super_diag = c;
        r.rhs = d;
        r.last_row = last;
        pending_rows.push_back(r);
    endtask

    // Sender: bursts and gaps, holding the item while tready is low.
    int gap_left;
    int burst_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tlast <= 1'b0;
            gap_left = 0;
            burst_left = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                sweep_row(pending_rows.pop_front());
                if (s_axis_tlast) systems_sent++;
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                // keep offering the same row
            end else if (hold_sender || pending_rows.size() == 0 || gap_left > 0) begin
                s_axis_tvalid <= 1'b0;
                if (gap_left > 0) gap_left--;
            end else begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {pending_rows[0].rhs, pending_rows[0].super_diag,
                                 pending_rows[0].diag, pending_rows[0].sub_diag};
                s_axis_tlast <= pending_rows[0].last_row;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 6);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 150);
                end
            end
        end
    end

    // Receiver: own stall pattern, plus one long hold-off on request.
    int stall_phase;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_phase = 0;
        end else if (long_stall > 0) begin
            m_axis_tready <= 1'b0;
            long_stall--;
        end else begin
            stall_phase = (stall_phase + 1) % 400;
            m_axis_tready <= (stall_phase < 120) ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    // Monitor: compare each accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        t_sol want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_sols.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $time, m_axis_tdata);
                fail_count++;
            end else begin
                want = expected_sols.pop_front();
                solutions_checked++;
                if (m_axis_tdata[31:0] !== want.solution) begin
                    $display("%0t: solution expected %h actual %h", $time,
                             want.solution, m_axis_tdata[31:0]);
                    fail_count++;
                end
                if (m_axis_tdata[37:32] !== want.row_index) begin
                    $display("%0t: row_index expected %0d actual %0d", $time,
                             want.row_index, m_axis_tdata[37:32]);
                    fail_count++;
                end
                if (m_axis_tlast !== want.last_value) begin
                    $display("%0t: last_value expected %b actual %b", $time,
                             want.last_value, m_axis_tlast);
                    fail_count++;
                end
                if (m_axis_tuser !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, m_axis_tuser);
                    fail_count++;
                end
            end
        end
    end

    // Hard stop well past the slowest correct run.
    initial begin
        #12ms;
        $display("Verification failed");
        $finish;
    end

    initial begin
        int drain;
        fail_count = 0;
        solutions_checked = 0;
        systems_sent = 0;
        pivot_systems = 0;
        overflow_systems = 0;
        hold_sender = 1'b0;
        long_stall = 0;
        rows_held = 0;
        err_seen = '0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: single row, field extremes, zero pivots, saturation.
        add_row(32'sh7fff_ffff, 32'sh0002_0000, 32'sh7fff_ffff, 32'sh0003_0000, 1'b1);
        add_row(32'sh8000_0000, 32'sh0000_0001, 32'sh8000_0000, 32'sh7fff_ffff, 1'b1);
        add_row(32'sh0, 32'sh0, 32'sh0001_0000, 32'sh0001_0000, 1'b1);
        add_row(32'sh8000_0000, 32'sh8000_0000, 32'shffff_ffff, 32'sh8000_0000, 1'b0);
        add_row(32'shffff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'shffff_ffff, 1'b1);
        add_row(32'sh0001_0000, 32'sh0, 32'sh0001_0000, 32'sh0002_0000, 1'b0);
        add_row(32'sh0001_0000, 32'sh0001_0000, 32'sh0, 32'sh0001_0000, 1'b0);
        add_row(32'sh0003_0000, 32'sh0, 32'sh1234_5678, 32'sh8000_0000, 1'b1);
        add_row(32'sh0, 32'sh0000_0100, 32'sh7fff_0000, 32'sh7fff_ffff, 1'b0);
        add_row(32'sh7fff_ffff, 32'sh0000_0100, 32'sh0, 32'sh8000_0001, 1'b1);
        pivot_systems += 3;

        // Too many rows, the last one past the store.
        add_system(MAX_ROWS + 1, 1'b0);
        overflow_systems++;
        wait (pending_rows.size() == 0 && expected_sols.size() == 0);

        // Long output hold-off during a back sweep while the next system waits.
        add_system(MAX_ROWS, 1'b0);
        add_system(4, 1'b0);
        wait (m_axis_tvalid);
        long_stall = 3000;
        wait (pending_rows.size() == 0);
        hold_sender = 1'b1;
        wait (expected_sols.size() == 0);
        hold_sender = 1'b0;

        // Random part: mostly small well-formed systems, some noise and overflow.
        while (systems_sent < 200 && pending_rows.size() + systems_sent * 3 < 400) begin
            case ($urandom_range(0, 19))
                0: begin
                    add_system(MAX_ROWS + $urandom_range(1, 3), 1'b0);
                    overflow_systems++;
                end
                1, 2, 3: add_system($urandom_range(1, 8), 1'b1);
                default: add_system($urandom_range(1, 6), 1'b0);
            endcase
            if (pending_rows.size() > 180) break;
        end
        wait (pending_rows.size() == 0);
        drain = 0;
        while (expected_sols.size() != 0 && drain < 200000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (300) @(posedge i_clk);

        $display("Solved %0d systems, %0d unknowns checked, incl. %0d overflowing systems",
                 systems_sent, solutions_checked, overflow_systems);
        $display("Directed zero-pivot and saturation systems: %0d", pivot_systems);
        if (fail_count == 0 && expected_sols.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
